// ===== hw/rtl/swm_pkg.sv =====
// swm_pkg: shared widths, constants and link types for the sliding window median.
// Used by swm_cell, swm_tap and sliding_window_median. No dependencies.
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int MEDIAN_W       = 33;
    localparam int SIZE_W         = 7;
    localparam int WINDOW_MAX_DEF = 64;
    localparam int TAP_GROUP      = 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);

    // neighbor link: a cell's value and its two compare results
    typedef struct packed {
        logic                       valid;
        logic                       le_v;   // valid and value <= new sample
        logic                       lt_x;   // valid and, when removing, value below the removed sample
        logic signed [SAMPLE_W-1:0] value;
    } cell_link_t;

    typedef struct packed {
        logic flush;      // empty the window
        logic update;     // apply one insert (and removal when set)
        logic remove;     // window full: the oldest sample leaves
        logic rm_below;   // removed sample <= new sample
    } cell_ctrl_t;

    typedef struct packed {
        logic hi;
        logic lo;
    } tap_sel_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] lo;
    } tap_t;

    localparam cell_link_t LINK_LEFT_END  = '{valid: 1'b1, le_v: 1'b1, lt_x: 1'b1, value: '0};
    localparam cell_link_t LINK_RIGHT_END = '{valid: 1'b0, le_v: 1'b0, lt_x: 1'b0, value: '0};

endpackage

`default_nettype wire

// ===== hw/rtl/swm_ram.sv =====
// swm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/swm_cell.sv =====
// swm_cell: one slot of the sorted window; updates from its two neighbors.
// Depends on swm_pkg.
`default_nettype none

module swm_cell (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire swm_pkg::cell_ctrl_t                ctrl,
    input  wire logic signed [swm_pkg::SAMPLE_W-1:0] sample_v,
    input  wire logic signed [swm_pkg::SAMPLE_W-1:0] removed_x,
    input  wire swm_pkg::cell_link_t                left,
    input  wire swm_pkg::cell_link_t                right,
    input  wire swm_pkg::tap_sel_t                  sel,
    output swm_pkg::cell_link_t                     link,
    output swm_pkg::tap_t                           tap
);

    import swm_pkg::*;

    logic                       valid_reg;
    logic                       valid_next;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;
    logic                       le_v;
    logic                       lt_x;

    assign le_v = valid_reg && (value_reg <= sample_v);
    assign lt_x = valid_reg && (!ctrl.remove || (value_reg < removed_x));

    assign link.valid = valid_reg;
    assign link.le_v  = le_v;
    assign link.lt_x  = lt_x;
    assign link.value = value_reg;

    assign tap.hi = sel.hi ? value_reg : '0;
    assign tap.lo = sel.lo ? value_reg : '0;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg || (!ctrl.remove && left.valid);
        if (ctrl.remove && ctrl.rm_below)
        begin
            // hole below the insertion point: cells in between move down
            if (lt_x)
                value_next = value_reg;
            else if (right.le_v)
                value_next = right.value;
            else if (le_v)
                value_next = sample_v;
        end
        else
        begin
            // insertion point below the hole (or no hole): cells move up
            if (le_v)
                value_next = value_reg;
            else if (left.le_v)
                value_next = sample_v;
            else if (left.lt_x)
                value_next = left.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.flush)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.update)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            value_reg <= value_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/swm_tap.sv =====
// swm_tap: gathers the two middle cells through a registered OR tree and adds them.
// Depends on swm_pkg.
`default_nettype none

module swm_tap #(
    parameter int N = swm_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                          clk,
    input  wire swm_pkg::tap_t                 taps [N],
    input  wire logic                          load_grp,
    input  wire logic                          load_out,
    output logic [swm_pkg::MEDIAN_W-1:0]       median
);

    import swm_pkg::*;

    localparam int G = (N + TAP_GROUP - 1) / TAP_GROUP;

    logic [SAMPLE_W-1:0] grp_hi_reg  [G];
    logic [SAMPLE_W-1:0] grp_lo_reg  [G];
    logic [SAMPLE_W-1:0] grp_hi_next [G];
    logic [SAMPLE_W-1:0] grp_lo_next [G];
    logic [SAMPLE_W-1:0] hi_all;
    logic [SAMPLE_W-1:0] lo_all;
    logic [MEDIAN_W-1:0] median_reg;
    logic [MEDIAN_W-1:0] median_next;

    always_comb
    begin
        for (int g = 0; g < G; g++)
        begin
            grp_hi_next[g] = '0;
            grp_lo_next[g] = '0;
            for (int m = 0; m < TAP_GROUP; m++)
            begin
                if (g * TAP_GROUP + m < N)
                begin
                    grp_hi_next[g] = grp_hi_next[g] | taps[g * TAP_GROUP + m].hi;
                    grp_lo_next[g] = grp_lo_next[g] | taps[g * TAP_GROUP + m].lo;
                end
            end
        end
    end

    always_comb
    begin
        hi_all = '0;
        lo_all = '0;
        for (int g = 0; g < G; g++)
        begin
            hi_all = hi_all | grp_hi_reg[g];
            lo_all = lo_all | grp_lo_reg[g];
        end
        median_next = {hi_all[SAMPLE_W-1], hi_all} + {lo_all[SAMPLE_W-1], lo_all};
    end

    always_ff @(posedge clk)
    begin
        if (load_grp)
        begin
            grp_hi_reg <= grp_hi_next;
            grp_lo_reg <= grp_lo_next;
        end
        if (load_out)
        begin
            median_reg <= median_next;
        end
    end

    assign median = median_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_median.sv =====
// sliding_window_median: running median over the last window_size samples.
// Depends on swm_pkg, swm_ram, swm_cell and swm_tap.
//
//  channel   direction  handshake             payload
//  in        request    in_valid / in_stall   start_of_sequence, sample
//  out       result     out_valid / out_stall median_doubled
//  cfg       write      cfg_write             cfg_data (window_size)
//
// A request passes through ring read, cell row update, tap tree and output
// register. in_stall is high while a request is in flight.
// Reset empties the window and sets window_size to 3; no clearing pass.
// A result held under out_stall keeps the last tap stage waiting.
`default_nettype none

module sliding_window_median #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [swm_pkg::SIZE_W-1:0]         cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               start_of_sequence,
    input  wire logic signed [swm_pkg::SAMPLE_W-1:0] sample,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [swm_pkg::MEDIAN_W-1:0]     median_doubled
);

    import swm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW    = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam logic [KW-1:0] MAX_K = KW'(WINDOW_MAX);

    logic [SIZE_W-1:0]          size_reg;
    logic [CNT_W-1:0]           fill_reg;
    logic [CNT_W-1:0]           fill_next;
    logic [PTR_W-1:0]           pos_reg;
    logic [PTR_W-1:0]           pos_next;
    logic                       s1_reg;
    logic                       s2_reg;
    logic                       s3_reg;
    logic                       emit_reg;
    logic                       emit_next;
    logic                       remove_reg;
    logic [PTR_W-1:0]           addr_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       out_valid_reg;

    logic [KW-1:0]              size_ext;
    logic [CNT_W-1:0]           k_eff;
    logic [CNT_W-1:0]           mid_hi;
    logic [CNT_W-1:0]           mid_lo;
    logic                       accept;
    logic [CNT_W-1:0]           fill_eff;
    logic [PTR_W-1:0]           pos_eff;
    logic [CNT_W-1:0]           pos_inc;
    logic                       full;
    logic                       load_out;
    logic [SAMPLE_W-1:0]        ring_rd;
    logic signed [SAMPLE_W-1:0] removed_x;
    cell_ctrl_t                 ctrl;
    cell_link_t                 links [WINDOW_MAX];
    tap_t                       taps  [WINDOW_MAX];
    logic [MEDIAN_W-1:0]        median;

    // effective window size
    always_comb
    begin
        size_ext = KW'(size_reg);
        if (size_ext == '0)
            k_eff = CNT_W'(1);
        else if (size_ext > MAX_K)
            k_eff = CNT_W'(MAX_K);
        else
            k_eff = CNT_W'(size_ext);
        mid_hi = k_eff >> 1;
        mid_lo = k_eff[0] ? mid_hi : (mid_hi - CNT_W'(1));
    end

    assign in_stall = s1_reg || s2_reg || s3_reg;
    assign accept   = in_valid && !in_stall;
    assign load_out = s3_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        fill_eff  = start_of_sequence ? '0 : fill_reg;
        pos_eff   = (start_of_sequence || (CNT_W'(pos_reg) >= k_eff)) ? '0 : pos_reg;
        full      = fill_eff >= k_eff;
        fill_next = full ? fill_eff : (fill_eff + CNT_W'(1));
        emit_next = fill_next == k_eff;
        pos_inc   = CNT_W'(pos_eff) + CNT_W'(1);
        pos_next  = (pos_inc >= k_eff) ? '0 : pos_inc[PTR_W-1:0];
    end

    swm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk     (clk),
        .wr_en   (s1_reg),
        .wr_addr (addr_reg),
        .wr_data (sample_reg),
        .rd_addr (pos_eff),
        .rd_data (ring_rd)
    );

    assign removed_x     = $signed(ring_rd);
    assign ctrl.flush    = cfg_write || (accept && start_of_sequence);
    assign ctrl.update   = s1_reg;
    assign ctrl.remove   = remove_reg;
    assign ctrl.rm_below = removed_x <= sample_reg;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        cell_link_t left;
        cell_link_t right;
        tap_sel_t   sel;

        if (i == 0)
        begin : g_first
            assign left = LINK_LEFT_END;
        end
        else
        begin : g_mid_l
            assign left = links[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_last
            assign right = LINK_RIGHT_END;
        end
        else
        begin : g_mid_r
            assign right = links[i+1];
        end

        assign sel.hi = mid_hi == CNT_W'(i);
        assign sel.lo = mid_lo == CNT_W'(i);

        swm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .sample_v  (sample_reg),
            .removed_x (removed_x),
            .left      (left),
            .right     (right),
            .sel       (sel),
            .link      (links[i]),
            .tap       (taps[i])
        );
    end

    swm_tap #(
        .N (WINDOW_MAX)
    ) u_tap (
        .clk      (clk),
        .taps     (taps),
        .load_grp (s2_reg),
        .load_out (load_out),
        .median   (median)
    );

    assign out_valid      = out_valid_reg;
    assign median_doubled = $signed(median);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            fill_reg      <= '0;
            pos_reg       <= '0;
            s1_reg        <= 1'b0;
            s2_reg        <= 1'b0;
            s3_reg        <= 1'b0;
            emit_reg      <= 1'b0;
            remove_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                size_reg <= cfg_data;
                fill_reg <= '0;
                pos_reg  <= '0;
            end
            else if (accept)
            begin
                fill_reg   <= fill_next;
                pos_reg    <= pos_next;
                emit_reg   <= emit_next;
                remove_reg <= full;
            end

            s1_reg <= accept;
            s2_reg <= s1_reg;
            if (s2_reg)
                s3_reg <= 1'b1;
            else if (load_out)
                s3_reg <= 1'b0;

            if (load_out && emit_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg   <= pos_eff;
            sample_reg <= sample;
        end
    end

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({s1_reg, s2_reg, s3_reg}))
        else $error("more than one request in flight");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_reg && in_stall)
        else $error("accepted request did not reach the cell row");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= k_eff)
        else $error("fill count above window size");

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_reg && emit_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("median not presented");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking bench for sliding_window_median, the running median filter.
// Needs swm_pkg and the sliding_window_median RTL. Directed table, then random
// phases at several window sizes, each result checked against a local model or the table's value.
`timescale 1ns / 100ps

module tb;

    import swm_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int DEPTH        = 64;
    localparam int IDLE_PCT     = 23;
    localparam int SETTLE       = 8;
    localparam int TAIL         = 20;
    localparam int STUCK_LIMIT  = 2000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_LEN     = 90;
    localparam int DIR_N        = 27;
    localparam int FIXED_N      = 9;
    localparam int PHASE_N      = 11;
    localparam int RAND_CNT     = 60;
    localparam int CALM_PHASE   = 6;

    typedef enum logic [0:0] {ROW_SAMPLE, ROW_SIZE} row_kind_e;

    typedef struct {
        row_kind_e                  kind;
        bit                         sos;
        logic signed [SAMPLE_W-1:0] value;
        bit                         typed;
        logic signed [MEDIAN_W-1:0] med;
    } dir_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [SIZE_W-1:0]          cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic                       start_of_sequence;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [MEDIAN_W-1:0] median_doubled;

    // local median model
    logic [SIZE_W-1:0]          size_reg;
    logic signed [SAMPLE_W-1:0] ring_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] sorted_mem [DEPTH];
    int                         fill_cnt;
    int                         ring_idx;

    logic signed [MEDIAN_W-1:0] median_q [$];
    logic signed [MEDIAN_W-1:0] exp_med;
    int                         errors;
    int                         results_seen;
    int                         stuck_cnt;
    bit                         calm;
    bit                         hold_done;
    int                         hold_left;

    dir_row_t dir_rows [DIR_N] = '{
        '{ROW_SAMPLE, 1'b0, 32'sd5,            1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, -32'sd7,           1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, 32'sd100,          1'b1, 33'sd10},
        '{ROW_SAMPLE, 1'b0, 32'sh7FFFFFFF,     1'b0, 33'sd0},
        '{ROW_SIZE,   1'b0, 32'sd1,            1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, 32'sh7FFFFFFF,     1'b1, 33'sh0FFFFFFFE},
        '{ROW_SAMPLE, 1'b0, 32'sh80000000,     1'b1, 33'sh100000000},
        '{ROW_SIZE,   1'b0, 32'sd0,            1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, 32'sd0,            1'b1, 33'sd0},
        '{ROW_SAMPLE, 1'b1, -32'sd1,           1'b1, -33'sd2},
        '{ROW_SIZE,   1'b0, 32'sd2,            1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, 32'sh7FFFFFFF,     1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, 32'sh7FFFFFFF,     1'b1, 33'sh0FFFFFFFE},
        '{ROW_SAMPLE, 1'b0, 32'sh80000000,     1'b1, -33'sd1},
        '{ROW_SIZE,   1'b0, 32'sd3,            1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, 32'sd1,            1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, 32'sd2,            1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b1, 32'sd9,            1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, 32'sd10,           1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, 32'sd11,           1'b1, 33'sd20},
        '{ROW_SAMPLE, 1'b0, 32'sd4,            1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, 32'sd4,            1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, 32'sd4,            1'b0, 33'sd0},
        '{ROW_SIZE,   1'b0, 32'sd127,          1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, 32'sh55555555,     1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b1, 32'shAAAAAAAA,     1'b0, 33'sd0},
        '{ROW_SAMPLE, 1'b0, -32'sd3,           1'b0, 33'sd0}
    };

    logic [SIZE_W-1:0] fixed_size [FIXED_N] = '{7'd5, 7'd1, 7'd64, 7'd2, 7'd0,
                                                 7'd127, 7'd7, 7'd65, 7'd3};
    int                fixed_cnt [FIXED_N]  = '{90, 60, 110, 70, 40, 90, 80, 80, 60};

    sliding_window_median dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .start_of_sequence (start_of_sequence),
        .sample            (sample),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .median_doubled    (median_doubled)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    function automatic int eff_size();
        int k;
        k = int'(size_reg);
        if (k == 0)
            k = 1;
        if (k > DEPTH)
            k = DEPTH;
        return k;
    endfunction

    function automatic bit median_step(input bit sos, input logic signed [SAMPLE_W-1:0] smp,
                                       output logic signed [MEDIAN_W-1:0] med);
        int                         k;
        int                         i;
        logic signed [SAMPLE_W-1:0] oldest;
        longint                     lo_v;
        longint                     hi_v;
        k = eff_size();
        med = '0;
        if (sos)
        begin
            fill_cnt = 0;
            ring_idx = 0;
        end
        if (ring_idx >= k)
            ring_idx = 0;
        if (fill_cnt >= k)
        begin
            oldest = ring_mem[ring_idx];
            i = 0;
            while (i < fill_cnt && sorted_mem[i] != oldest)
                i++;
            if (i < fill_cnt)
            begin
                for (; i + 1 < fill_cnt; i++)
                    sorted_mem[i] = sorted_mem[i + 1];
                fill_cnt--;
            end
        end
        ring_mem[ring_idx] = smp;
        if (fill_cnt < DEPTH)
        begin
            i = fill_cnt;
            while (i > 0 && sorted_mem[i - 1] > smp)
            begin
                sorted_mem[i] = sorted_mem[i - 1];
                i--;
            end
            sorted_mem[i] = smp;
            fill_cnt++;
        end
        ring_idx++;
        if (ring_idx >= k)
            ring_idx = 0;
        if (fill_cnt != k)
            return 1'b0;
        if (k % 2 == 1)
        begin
            lo_v = sorted_mem[k / 2];
            med = MEDIAN_W'(2 * lo_v);
        end
        else
        begin
            lo_v = sorted_mem[k / 2 - 1];
            hi_v = sorted_mem[k / 2];
            med = MEDIAN_W'(lo_v + hi_v);
        end
        return 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 32'sh80000000;
            1: return 32'sh7FFFFFFF;
            2, 3, 4: return $signed(32'($urandom_range(0, 8))) - 32'sd4;
            default: return $signed($urandom);
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_request(input bit sos, input logic signed [SAMPLE_W-1:0] smp,
                                input bit typed, input logic signed [MEDIAN_W-1:0] typed_med);
        bit                         produced;
        logic signed [MEDIAN_W-1:0] med;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid          <= 1'b1;
        start_of_sequence <= sos;
        sample            <= smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        produced = median_step(sos, smp, med);
        if (produced)
            median_q.insert(median_q.size(), typed ? typed_med : med);
    endtask

    // drain, let the pipe settle, then write window_size
    task automatic write_size(input logic [SIZE_W-1:0] v);
        in_valid <= 1'b0;
        while (median_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        size_reg = v;
        fill_cnt = 0;
        ring_idx = 0;
    endtask

    // receiver: random stall, one long hold-off once results are flowing
    initial
    begin
        out_stall <= 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (median_q.size() == 0)
            begin
                $display("%0t: median with none expected, expected none actual %0d",
                         $time, median_doubled);
                errors++;
            end
            else
            begin
                exp_med = median_q.pop_front();
                if (median_doubled !== exp_med)
                begin
                    $display("%0t: median_doubled mismatch, expected %0d actual %0d",
                             $time, exp_med, median_doubled);
                    errors++;
                end
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cnt = 0;
        else
            stuck_cnt++;
        if (stuck_cnt >= STUCK_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        int                         p;
        int                         n;
        int                         cnt;
        logic [SIZE_W-1:0]          sz;
        bit                         sos;
        errors            = 0;
        results_seen      = 0;
        stuck_cnt         = 0;
        calm              = 1'b0;
        size_reg          = swm_pkg::SIZE_RESET;
        fill_cnt          = 0;
        ring_idx          = 0;
        rst_n             <= 1'b0;
        cfg_write         <= 1'b0;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        start_of_sequence <= 1'b0;
        sample            <= '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (n = 0; n < DIR_N; n++)
        begin
            if (dir_rows[n].kind == ROW_SIZE)
                write_size(dir_rows[n].value[SIZE_W-1:0]);
            else
                send_request(dir_rows[n].sos, dir_rows[n].value,
                             dir_rows[n].typed, dir_rows[n].med);
        end

        for (p = 0; p < PHASE_N; p++)
        begin
            if (p < FIXED_N)
            begin
                sz  = fixed_size[p];
                cnt = fixed_cnt[p];
            end
            else
            begin
                sz  = SIZE_W'($urandom_range(1, 24));
                cnt = RAND_CNT;
            end
            write_size(sz);
            calm = (p == CALM_PHASE);
            for (n = 0; n < cnt; n++)
            begin
                // rare restarts so large windows still fill
                sos = $urandom_range(0, 99) < ((eff_size() >= 32) ? 1 : 5);
                send_request(sos, random_sample(), 1'b0, '0);
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (median_q.size() != 0)
            @(negedge clk);
        repeat (TAIL) @(negedge clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
